[hdl/frms_pkg.sv]
package frms_pkg;

  // Sample format and fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
  localparam int THR_W       = 15;
  localparam int ACT_W       = 16;
  localparam int GAIN_W      = 8;
  localparam int CONF_W      = 16;
  localparam int CROSS_W     = 13;
  localparam int ROOT_W      = 16;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int ROOT_STEPS  = ROOT_W;
  localparam int PROD_W      = ROOT_W + GAIN_W;

  // Stream word widths
  localparam int IN_DATA_W   = 16;
  localparam int OUT_FIELD_W = 1 + CONF_W + CROSS_W + ROOT_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Default frame length limit
  localparam int MAX_FRAME_DEF = 4096;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_CROSSING_THR = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVITY_THR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CONF_GAIN    = 2'd2;

  localparam logic [THR_W-1:0]  CROSSING_THR_RST = 15'd1638;
  localparam logic [ACT_W-1:0]  ACTIVITY_THR_RST = 16'd655;
  localparam logic [GAIN_W-1:0] CONF_GAIN_RST    = 8'd8;

  // Confidence of 1.0 in Q1.15
  localparam logic [PROD_W-1:0] CONF_ONE = 24'd32768;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_SQRT,
    ST_CONF,
    ST_HOLD
  } state_t;

  // Commands from the sequencer to the divide and root unit
  typedef struct packed {
    logic load;
    logic div_step;
    logic div_last;
    logic sqrt_step;
  } isu_ctrl_t;

endpackage

[hdl/frms_acc.sv]
module frms_acc #(
  parameter int MAX_FRAME = frms_pkg::MAX_FRAME_DEF,
  parameter int CNT_W     = 13,
  parameter int SUM_W     = 43
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic signed [frms_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  last_sample,
  input  logic [frms_pkg::THR_W-1:0]            crossing_threshold,
  input  logic                                  add_en,
  input  logic                                  clear,
  output logic [SUM_W-1:0]                      square_sum,
  output logic [CNT_W-1:0]                      sample_total,
  output logic [CNT_W-1:0]                      crossing_total,
  output logic                                  close
);
  import frms_pkg::*;

  logic signed [SAMPLE_BITS-1:0]   previous_sample;
  logic [SQ_W-1:0]                 square;
  logic signed [2*SAMPLE_BITS-1:0] sq_full;
  logic signed [SAMPLE_BITS:0]     cur_x;
  logic signed [SAMPLE_BITS:0]     prev_x;
  logic signed [SAMPLE_BITS:0]     thr_pos;
  logic signed [SAMPLE_BITS:0]     thr_neg;
  logic                            hit;

  // Square of the incoming sample and the level-crossing test
  always_comb begin
    sq_full = sample * sample;
    cur_x   = {sample[SAMPLE_BITS-1], sample};
    prev_x  = {previous_sample[SAMPLE_BITS-1], previous_sample};
    thr_pos = $signed({{(SAMPLE_BITS + 1 - THR_W){1'b0}}, crossing_threshold});
    thr_neg = -thr_pos;
    hit     = ((prev_x < thr_pos) && (cur_x >= thr_pos)) ||
              ((prev_x > thr_neg) && (cur_x <= thr_neg));
  end

  // The square is registered on acceptance and added in the following cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      square <= sq_full[SQ_W-1:0];
    end
  end

  // Frame state, cleared at reset and once the frame has been handed over
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      square_sum      <= '0;
      sample_total    <= '0;
      crossing_total  <= '0;
      previous_sample <= '0;
      close           <= 1'b0;
    end else begin
      if (accept) begin
        previous_sample <= sample;
        sample_total    <= sample_total + 1'b1;
        close           <= last_sample || (sample_total == CNT_W'(MAX_FRAME - 1));
        if (hit) begin
          crossing_total <= crossing_total + 1'b1;
        end
      end
      if (add_en) begin
        square_sum <= square_sum + SUM_W'(square);
      end
    end
  end

endmodule

[hdl/frms_isu.sv]
module frms_isu #(
  parameter int CNT_W = 13,
  parameter int SUM_W = 43
) (
  input  logic                        clk,
  input  frms_pkg::isu_ctrl_t         ctrl,
  input  logic [SUM_W-1:0]            square_sum,
  input  logic [CNT_W-1:0]            sample_total,
  output logic [frms_pkg::ROOT_W-1:0] rms_level
);
  import frms_pkg::*;

  // Remainder width covers both the divider and the root remainder.
  localparam int SUB_W = (CNT_W + 1 > ROOT_W + 3) ? CNT_W + 1 : ROOT_W + 3;

  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  divisor;
  logic [SUB_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [SUB_W-1:0]  op_a;
  logic [SUB_W-1:0]  op_b;
  logic [SUB_W:0]    diff;
  logic              ge;
  logic [SUB_W-1:0]  res;

  // Shared compare-and-subtract: one quotient bit or one root bit per cycle
  always_comb begin
    if (ctrl.sqrt_step) begin
      op_a = {rem[SUB_W-3:0], quo[RAD_W-1:RAD_W-2]};
      op_b = SUB_W'({root, 2'b01});
    end else begin
      op_a = {rem[SUB_W-2:0], quo[SUM_W-1]};
      op_b = SUB_W'(divisor);
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[SUB_W];
    res  = ge ? diff[SUB_W-1:0] : op_a;
  end

  // The dividend register shifts out dividend bits and collects the quotient;
  // its low RAD_W bits then serve as the radicand for the root.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo     <= square_sum;
      divisor <= sample_total;
      rem     <= '0;
      root    <= '0;
    end else if (ctrl.div_step) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ctrl.div_last ? '0 : res;
    end else if (ctrl.sqrt_step) begin
      quo[RAD_W-1:0] <= {quo[RAD_W-3:0], 2'b00};
      rem            <= res;
      root           <= {root[ROOT_W-2:0], ge};
    end
  end

  assign rms_level = root;

endmodule

[hdl/frame_rms_and_level_crossings_core.sv]
// Frame RMS level and level-crossing counter.
// Samples arrive on the s_ stream, one Q1.15 sample per word, with s_tlast on
// the final sample of a frame. Each frame yields one result word on the m_
// stream: activity flag, saturated confidence, crossing count and RMS level.
// A frame that reaches MAX_FRAME samples is closed at that sample.
// Within a frame, each sample is squared and then added before the next is taken.
// After the final sample, the shared compare-and-subtract unit produces one
// quotient bit per cycle for the mean (SUM_W bits) and then one root bit per
// cycle for the RMS (16 bits). No sample is taken while that unit is busy.
// The result sits in an output register; once it is loaded the core takes the
// next frame's samples even while the receiver holds m_tready low. A further
// result waits inside the core until the output register is free.
// Configuration is written through cfg_wr_en, cfg_addr and cfg_wdata; the user
// must change it only while no frame is in progress; the core does not enforce it.
// Reset (rst, synchronous) restores the register defaults, clears the frame
// state and drops m_tvalid.
module frame_rms_and_level_crossings_core #(
  parameter int MAX_FRAME = frms_pkg::MAX_FRAME_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [frms_pkg::IN_DATA_W-1:0]      s_tdata,  // [15:0] sample
  input  logic                                s_tlast,
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] activity, [16:1] confidence, [29:17] crossing_count,
  // [45:30] rms_level, [47:46] zero
  output logic [frms_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Configuration port
  input  logic                                cfg_wr_en,
  input  logic [frms_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [frms_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import frms_pkg::*;

  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int SUM_W  = SQ_W - 1 + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  state_t             state;
  state_t             state_next;
  logic [STEP_W-1:0]  step;
  isu_ctrl_t          ctrl;
  logic               accept;
  logic               add_en;
  logic               acc_clear;
  logic               conf_en;
  logic               out_load;
  logic               step_zero;

  logic [THR_W-1:0]   crossing_threshold;
  logic [ACT_W-1:0]   activity_threshold;
  logic [GAIN_W-1:0]  confidence_gain;

  logic [SUM_W-1:0]   square_sum;
  logic [CNT_W-1:0]   sample_total;
  logic [CNT_W-1:0]   crossing_total;
  logic               close;
  logic [ROOT_W-1:0]  rms;

  logic [CROSS_W-1:0] cross_res;
  logic [PROD_W-1:0]  conf_prod;
  logic [CONF_W-1:0]  conf_sat;

  logic               out_activity;
  logic [CONF_W-1:0]  out_confidence;
  logic [CROSS_W-1:0] out_crossing;
  logic [ROOT_W-1:0]  out_rms;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_threshold <= CROSSING_THR_RST;
      activity_threshold <= ACTIVITY_THR_RST;
      confidence_gain    <= CONF_GAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_CROSSING_THR: crossing_threshold <= cfg_wdata[THR_W-1:0];
        REG_ACTIVITY_THR: activity_threshold <= cfg_wdata[ACT_W-1:0];
        REG_CONF_GAIN:    confidence_gain    <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept    = s_tvalid && s_tready;
  assign step_zero = (step == '0);

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_ACC;
      ST_ACC:  state_next = close ? ST_LOAD : ST_IDLE;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (step_zero) state_next = ST_SQRT;
      ST_SQRT: if (step_zero) state_next = ST_CONF;
      ST_CONF: state_next = ST_HOLD;
      ST_HOLD: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_tready       = 1'b0;
    add_en         = 1'b0;
    acc_clear      = 1'b0;
    conf_en        = 1'b0;
    out_load       = 1'b0;
    ctrl           = '0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_ACC:  add_en = 1'b1;
      ST_LOAD: begin
        acc_clear = 1'b1;
        ctrl.load = 1'b1;
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        ctrl.div_last = step_zero;
      end
      ST_SQRT: ctrl.sqrt_step = 1'b1;
      ST_CONF: conf_en = 1'b1;
      ST_HOLD: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Iteration counter for the divide and root passes
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: step <= STEP_W'(SUM_W - 1);
      ST_DIV:  step <= step_zero ? STEP_W'(ROOT_STEPS - 1) : step - 1'b1;
      ST_SQRT: step <= step - 1'b1;
      default: ;
    endcase
  end

  frms_acc #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_acc (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .sample             ($signed(s_tdata[SAMPLE_BITS-1:0])),
    .last_sample        (s_tlast),
    .crossing_threshold (crossing_threshold),
    .add_en             (add_en),
    .clear              (acc_clear),
    .square_sum         (square_sum),
    .sample_total       (sample_total),
    .crossing_total     (crossing_total),
    .close              (close)
  );

  frms_isu #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_isu (
    .clk          (clk),
    .ctrl         (ctrl),
    .square_sum   (square_sum),
    .sample_total (sample_total),
    .rms_level    (rms)
  );

  // Crossing count is captured when the frame is handed to the unit.
  always_ff @(posedge clk) begin
    if (acc_clear) begin
      cross_res <= CROSS_W'(crossing_total);
    end
  end

  // Confidence product, saturated to 1.0 when the result is loaded
  always_ff @(posedge clk) begin
    if (conf_en) begin
      conf_prod <= PROD_W'(rms) * PROD_W'(confidence_gain);
    end
  end

  assign conf_sat = (conf_prod > CONF_ONE) ? CONF_ONE[CONF_W-1:0] : conf_prod[CONF_W-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_activity   <= (rms > activity_threshold);
      out_confidence <= conf_sat;
      out_crossing   <= cross_res;
      out_rms        <= rms;
    end
  end

  assign m_tdata = OUT_DATA_W'({out_rms, out_crossing, out_confidence, out_activity});

endmodule
